// File: hdl/lc3s_pkg.sv
package lc3s_pkg;

  localparam logic [15:0] PC_RESET = 16'h3000;
  localparam logic [2:0] FLAG_N = 3'd4;
  localparam logic [2:0] FLAG_Z = 3'd2;
  localparam logic [2:0] FLAG_P = 3'd1;
  localparam logic [7:0] TRAP_OUT = 8'h21;
  localparam logic [7:0] TRAP_HALT = 8'h25;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_HALTED = 2'd1,
    ST_ILLEGAL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    OP_BR = 4'h0, OP_ADD = 4'h1, OP_LD = 4'h2, OP_ST = 4'h3,
    OP_JSR = 4'h4, OP_AND = 4'h5, OP_LDR = 4'h6, OP_STR = 4'h7,
    OP_RTI = 4'h8, OP_NOT = 4'h9, OP_LDI = 4'hA, OP_STI = 4'hB,
    OP_JMP = 4'hC, OP_RES = 4'hD, OP_LEA = 4'hE, OP_TRAP = 4'hF
  } opcode_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_FETCH, S_EXEC, S_IND, S_DATA, S_OUT
  } state_t;

  function automatic logic [2:0] flags_of(input logic [15:0] v);
    if (v == 16'd0) return FLAG_Z;
    else if (v[15]) return FLAG_N;
    else return FLAG_P;
  endfunction

endpackage

// File: hdl/lc3_instruction_step.sv
// LC-3 style processor that runs one instruction per step transfer.
// Input channel (in_valid/in_ready): in_operation 1 writes in_load_data at
// in_load_address into the word memory; 0 executes the instruction at the PC.
// Result channel (out_valid/out_ready): one result per input transfer with
// status, pc after, flags, and a character for the output trap.
// A load or a step while halted goes from idle straight to the output state;
// other steps pass fetch and execute, LD/LDR/ST/STR add a data state and
// LDI/STI an indirection and a data state, because fetch, indirection and
// data access share one memory port with a registered read.
// in_ready returns when the result is registered, so a new item is taken
// only after the last one has left for the output register.
// A halted processor answers each step with status halted until reset.
// Reset (rst_n low, synchronous) sets the PC to 0x3000, flags to Z,
// clears registers and the halt flag, then zeroes the word memory one word
// per cycle: in_ready stays low until every word is cleared.
// When out_ready is low, the result holds in the output register; the next
// item runs and waits at its last cycle until that register is free.
module lc3_instruction_step
  import lc3s_pkg::*;
#(
  parameter int ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [15:0] in_load_address,
  input  logic [15:0] in_load_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_pc_after,
  output logic [2:0]  out_flags_after,
  output logic        out_char_valid,
  output logic [7:0]  out_char_out
);

  localparam int MEM_WORDS = 1 << ADDR_BITS;

  // word memory, one port
  logic [15:0] mem [MEM_WORDS];
  logic [ADDR_BITS-1:0] mem_addr;
  logic mem_we;
  logic [15:0] mem_wdata, mem_rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_rdata_r <= mem[mem_addr];
  end

  state_t state_r, state_nxt;
  logic [15:0] regs_r [8];
  logic [15:0] pc_r, ins_r;
  logic [2:0] flags_r;
  logic halted_r;
  logic busy_in;
  logic [ADDR_BITS-1:0] clr_r;

  // per-item status and character
  logic [1:0] ostat_r;
  logic ochar_v_r;
  logic [7:0] ochar_r;

  // output register
  logic out_full_r, out_full_nxt, out_load;
  logic [1:0] out_stat_r;
  logic [15:0] out_pc_r;
  logic [2:0] out_flags_r;
  logic out_cv_r;
  logic [7:0] out_char_r;

  // decode
  opcode_t op;
  logic [2:0] dr, s1;
  logic [15:0] pc1, off9, off6, off11, opb, sr1v, drv, addr9, addr6;
  always_comb begin
    op = opcode_t'(ins_r[15:12]);
    dr = ins_r[11:9];
    s1 = ins_r[8:6];
    pc1 = pc_r + 16'd1;
    off9 = {{7{ins_r[8]}}, ins_r[8:0]};
    off6 = {{10{ins_r[5]}}, ins_r[5:0]};
    off11 = {{5{ins_r[10]}}, ins_r[10:0]};
    sr1v = regs_r[s1];
    drv = regs_r[dr];
    opb = ins_r[5] ? {{11{ins_r[4]}}, ins_r[4:0]} : regs_r[ins_r[2:0]];
    addr9 = pc1 + off9;
    addr6 = sr1v + off6;
  end

  assign in_ready = (state_r == S_IDLE);
  assign busy_in = in_valid && in_ready;

  // result register loads when it is empty or being drained
  assign out_load = (state_r == S_OUT) && (!out_full_r || out_ready);

  always_comb begin
    if (out_load) out_full_nxt = 1'b1;
    else if (out_ready) out_full_nxt = 1'b0;
    else out_full_nxt = out_full_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == {ADDR_BITS{1'b1}}) state_nxt = S_IDLE;
      S_IDLE: if (busy_in) state_nxt = (in_operation || halted_r) ? S_OUT : S_FETCH;
      S_FETCH: state_nxt = S_EXEC;
      S_EXEC: begin
        unique case (op)
          OP_LD, OP_LDR, OP_ST, OP_STR: state_nxt = S_DATA;
          OP_LDI, OP_STI: state_nxt = S_IND;
          default: state_nxt = S_OUT;
        endcase
      end
      S_IND: state_nxt = S_DATA;
      S_DATA: state_nxt = S_OUT;
      S_OUT: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_wdata = drv;
    mem_addr = pc_r[ADDR_BITS-1:0];
    unique case (state_r)
      S_CLEAR: begin
        mem_addr = clr_r;
        mem_we = 1'b1;
        mem_wdata = 16'd0;
      end
      S_IDLE: begin
        mem_addr = busy_in && in_operation ? in_load_address[ADDR_BITS-1:0]
                                           : pc_r[ADDR_BITS-1:0];
        mem_we = busy_in && in_operation;
        mem_wdata = in_load_data;
      end
      S_EXEC: begin
        mem_addr = (op == OP_LDR || op == OP_STR) ? addr6[ADDR_BITS-1:0]
                                                  : addr9[ADDR_BITS-1:0];
        mem_we = (op == OP_ST) || (op == OP_STR);
      end
      S_IND: begin
        mem_addr = mem_rdata_r[ADDR_BITS-1:0];
        mem_we = (op == OP_STI);
      end
      default: mem_addr = pc_r[ADDR_BITS-1:0];
    endcase
  end

  assign out_valid = out_full_r;

  // architectural state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      pc_r <= PC_RESET;
      flags_r <= FLAG_Z;
      halted_r <= 1'b0;
      out_full_r <= 1'b0;
      for (int i = 0; i < 8; i++) regs_r[i] <= 16'd0;
    end else begin
      state_r <= state_nxt;
      out_full_r <= out_full_nxt;
      unique case (state_r)
        S_CLEAR: clr_r <= clr_r + 1'b1;
        S_IDLE: if (busy_in) begin
          ostat_r <= (!in_operation && halted_r) ? ST_HALTED : ST_DONE;
          ochar_v_r <= 1'b0;
          ochar_r <= 8'd0;
        end
        S_FETCH: ins_r <= mem_rdata_r;
        S_EXEC: begin
          pc_r <= pc1;
          unique case (op)
            OP_ADD: begin
              regs_r[dr] <= sr1v + opb; flags_r <= flags_of(sr1v + opb);
            end
            OP_AND: begin
              regs_r[dr] <= sr1v & opb; flags_r <= flags_of(sr1v & opb);
            end
            OP_NOT: begin
              regs_r[dr] <= ~sr1v; flags_r <= flags_of(~sr1v);
            end
            OP_BR: if ((dr & flags_r) != 3'd0) pc_r <= addr9;
            OP_JMP: pc_r <= sr1v;
            OP_JSR: begin
              regs_r[7] <= pc1;
              pc_r <= ins_r[11] ? pc1 + off11 : sr1v;
            end
            OP_LEA: begin
              regs_r[dr] <= addr9; flags_r <= flags_of(addr9);
            end
            OP_TRAP: begin
              regs_r[7] <= pc1;
              if (ins_r[7:0] == TRAP_OUT) begin
                ochar_v_r <= 1'b1;
                ochar_r <= regs_r[0][7:0];
              end else if (ins_r[7:0] == TRAP_HALT) begin
                halted_r <= 1'b1;
                ostat_r <= ST_HALTED;
              end
            end
            OP_RES: ostat_r <= ST_ILLEGAL;
            default: ;
          endcase
        end
        S_DATA: if (op == OP_LD || op == OP_LDR || op == OP_LDI) begin
          regs_r[dr] <= mem_rdata_r; flags_r <= flags_of(mem_rdata_r);
        end
        default: ;
      endcase
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_stat_r <= ostat_r;
      out_pc_r <= pc_r;
      out_flags_r <= flags_r;
      out_cv_r <= ochar_v_r;
      out_char_r <= ochar_r;
    end
  end

  assign out_status = out_stat_r;
  assign out_pc_after = out_pc_r;
  assign out_flags_after = out_flags_r;
  assign out_char_valid = out_cv_r;
  assign out_char_out = out_char_r;

endmodule

// File: bench/lc3_step_checker.sv
`timescale 1ns / 100ps

module lc3_step_checker
  import lc3s_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_operation,
  input  logic [15:0] in_load_address,
  input  logic [15:0] in_load_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [15:0] out_pc_after,
  input  logic [2:0]  out_flags_after,
  input  logic        out_char_valid,
  input  logic [7:0]  out_char_out,
  output int          errors
);

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] pc;
    logic [2:0]  flags;
    logic        cvalid;
    logic [7:0]  cbyte;
  } step_result_t;

  // shadow machine state
  logic [15:0] gpr [0:7];
  logic [15:0] pc_q;
  logic [15:0] ram [0:65535];
  logic [2:0]  cc;
  logic        stopped;

  step_result_t results_due[$];

  function automatic logic [15:0] sext(input logic [15:0] v, input int w);
    logic [15:0] r;
    r = v;
    for (int i = w; i < 16; i++) r[i] = v[w-1];
    return r;
  endfunction

  function automatic void set_reg(input logic [2:0] r, input logic [15:0] v);
    gpr[r] = v;
    cc = (v == 16'd0) ? FLAG_Z : (v[15] ? FLAG_N : FLAG_P);
  endfunction

  // execute one transfer on the shadow machine and return its result
  function automatic step_result_t run_item(input logic op, input logic [15:0] addr,
                                            input logic [15:0] data);
    step_result_t r;
    logic [15:0] ins, npc, opb, ea, tgt;
    opcode_t oc;
    r = '0;
    r.status = ST_DONE;
    if (op) begin
      ram[addr] = data;
    end else if (stopped) begin
      r.status = ST_HALTED;
    end else begin
      ins = ram[pc_q];
      oc = opcode_t'(ins[15:12]);
      npc = pc_q + 16'd1;
      opb = ins[5] ? sext(ins, 5) : gpr[ins[2:0]];
      case (oc)
        OP_ADD: set_reg(ins[11:9], gpr[ins[8:6]] + opb);
        OP_AND: set_reg(ins[11:9], gpr[ins[8:6]] & opb);
        OP_NOT: set_reg(ins[11:9], ~gpr[ins[8:6]]);
        OP_BR: if ((ins[11:9] & cc) != 3'd0) npc = npc + sext(ins, 9);
        OP_JMP: npc = gpr[ins[8:6]];
        OP_JSR: begin
          tgt = ins[11] ? npc + sext(ins, 11) : gpr[ins[8:6]];
          gpr[7] = npc;
          npc = tgt;
        end
        OP_LD: set_reg(ins[11:9], ram[npc + sext(ins, 9)]);
        OP_LDI: begin
          ea = ram[npc + sext(ins, 9)];
          set_reg(ins[11:9], ram[ea]);
        end
        OP_LDR: set_reg(ins[11:9], ram[gpr[ins[8:6]] + sext(ins, 6)]);
        OP_LEA: set_reg(ins[11:9], npc + sext(ins, 9));
        OP_ST: ram[npc + sext(ins, 9)] = gpr[ins[11:9]];
        OP_STI: begin
          ea = ram[npc + sext(ins, 9)];
          ram[ea] = gpr[ins[11:9]];
        end
        OP_STR: ram[gpr[ins[8:6]] + sext(ins, 6)] = gpr[ins[11:9]];
        OP_RTI: ;
        OP_TRAP: begin
          gpr[7] = npc;
          if (ins[7:0] == TRAP_OUT) begin
            r.cvalid = 1'b1;
            r.cbyte = gpr[0][7:0];
          end else if (ins[7:0] == TRAP_HALT) begin
            stopped = 1'b1;
            r.status = ST_HALTED;
          end
        end
        default: r.status = ST_ILLEGAL;
      endcase
      pc_q = npc;
    end
    r.pc = pc_q;
    r.flags = cc;
    return r;
  endfunction

  initial begin
    for (int i = 0; i < 8; i++) gpr[i] = '0;
    for (int i = 0; i < 65536; i++) ram[i] = '0;
    pc_q = PC_RESET;
    cc = FLAG_Z;
    stopped = 1'b0;
    errors = 0;
  end

  // compare result transfers, then predict input transfers
  always @(posedge clk) begin
    step_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result status=%0d pc=%h", $time, out_status,
                   out_pc_after);
          errors++;
        end else begin
          want = results_due.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
            errors++;
          end
          if (out_pc_after !== want.pc) begin
            $display("%0t: pc_after expected %h actual %h", $time, want.pc, out_pc_after);
            errors++;
          end
          if (out_flags_after !== want.flags) begin
            $display("%0t: flags_after expected %0d actual %0d", $time, want.flags,
                     out_flags_after);
            errors++;
          end
          if (out_char_valid !== want.cvalid) begin
            $display("%0t: char_valid expected %0d actual %0d", $time, want.cvalid,
                     out_char_valid);
            errors++;
          end
          if (out_char_out !== want.cbyte) begin
            $display("%0t: char_out expected %h actual %h", $time, want.cbyte, out_char_out);
            errors++;
          end
        end
      end
      if (in_valid && in_ready)
        results_due.push_back(run_item(in_operation, in_load_address, in_load_data));
    end
  end

endmodule

// File: bench/tb_lc3_instruction_step.sv
`timescale 1ns / 100ps

module tb_lc3_instruction_step
  import lc3s_pkg::*;
();

  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_STEPS = 200;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_operation;
  logic [15:0] in_load_address;
  logic [15:0] in_load_data;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [15:0] out_pc_after;
  logic [2:0]  out_flags_after;
  logic        out_char_valid;
  logic [7:0]  out_char_out;
  int          errors;

  int          sent_cnt;
  int          got_cnt;
  int          cycles;
  int          step_cnt;
  int          char_cnt;
  logic [15:0] cur_pc;
  logic        calm;

  lc3_instruction_step dut (.*);

  lc3_step_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: random stalls, and track the pc for program placement
  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 8);
    if (rst_n && out_valid && out_ready) begin
      got_cnt <= got_cnt + 1;
      cur_pc <= out_pc_after;
      if (out_char_valid) char_cnt <= char_cnt + 1;
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_lc3_instruction_step: FAIL");
      $finish;
    end
  end

  task automatic send(input logic op, input logic [15:0] addr, input logic [15:0] data);
    if (!calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_load_address <= addr;
    in_load_data <= data;
    do @(posedge clk); while (!in_ready);
    sent_cnt++;
    if (!op) step_cnt++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (got_cnt != sent_cnt);
  endtask

  // place one instruction at the current pc and execute it
  task automatic exec(input logic [15:0] ins);
    drain();
    send(1'b1, cur_pc, ins);
    send(1'b0, 16'($urandom), 16'($urandom));
  endtask

  function automatic logic [15:0] rand_ins();
    logic [15:0] w;
    w = 16'($urandom);
    // keep the halt trap for the end, and favor the character trap
    if (w[15:12] == OP_TRAP) begin
      case ($urandom_range(3))
        0: w[7:0] = TRAP_OUT;
        1: w[7:0] = 8'h22;
        default: if (w[7:0] == TRAP_HALT) w[7:0] = TRAP_OUT;
      endcase
    end
    return w;
  endfunction

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = 1'b0;
    in_load_address = '0;
    in_load_data = '0;
    out_ready = 1'b0;
    sent_cnt = 0;
    got_cnt = 0;
    cycles = 0;
    step_cnt = 0;
    char_cnt = 0;
    cur_pc = PC_RESET;
    calm = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: each opcode and the corner cases of the fields
    exec({OP_ADD, 3'd1, 3'd1, 1'b1, 5'h0F});
    exec({OP_ADD, 3'd2, 3'd1, 1'b1, 5'h10});
    exec({OP_ADD, 3'd3, 3'd1, 1'b0, 2'b00, 3'd2});
    exec({OP_AND, 3'd4, 3'd2, 1'b1, 5'h00});
    exec({OP_AND, 3'd5, 3'd2, 1'b0, 2'b00, 3'd3});
    exec({OP_NOT, 3'd6, 3'd4, 6'h3F});
    exec({OP_NOT, 3'd0, 3'd6, 6'h3F});
    exec({OP_BR, 3'b000, 9'h001});
    exec({OP_BR, 3'b111, 9'h002});
    exec({OP_BR, 3'b010, 9'h100});
    exec({OP_LEA, 3'd1, 9'h0FF});
    exec({OP_LEA, 3'd2, 9'h100});
    exec({OP_JMP, 3'd0, 3'd1, 6'd0});
    exec({OP_JSR, 1'b1, 11'h7FF});
    exec({OP_JSR, 1'b1, 11'h400});
    exec({OP_JSR, 1'b0, 2'b00, 3'd2, 6'd0});
    exec({OP_LD, 3'd3, 9'h0FF});
    exec({OP_LDI, 3'd4, 9'h1FF});
    exec({OP_LDR, 3'd5, 3'd3, 6'h20});
    exec({OP_ST, 3'd5, 9'h003});
    exec({OP_STI, 3'd4, 9'h002});
    exec({OP_STR, 3'd3, 3'd2, 6'h1F});
    exec({OP_RTI, 12'h000});
    exec({OP_RES, 12'hFFF});
    exec({OP_TRAP, 4'h0, TRAP_OUT});
    exec({OP_TRAP, 4'h0, 8'h22});

    // random programs: instruction at the pc, a step, then scattered loads and sometimes another step
    for (int i = 0; i < RANDOM_STEPS; i++) begin
      calm = (i >= 80 && i < 130);
      drain();
      send(1'b1, cur_pc, rand_ins());
      send(1'b0, 16'($urandom), 16'($urandom));
      repeat ($urandom_range(2)) send(1'b1, 16'($urandom), 16'($urandom));
      if ($urandom_range(3) == 0) send(1'b0, 16'($urandom), 16'($urandom));
    end
    calm = 1'b0;

    // halt, then steps and a load while halted
    exec({OP_TRAP, 4'h0, TRAP_HALT});
    send(1'b0, 16'hFFFF, 16'hFFFF);
    send(1'b1, 16'hFFFF, 16'h0000);
    send(1'b0, 16'h0000, 16'h0000);

    drain();
    repeat (20) @(posedge clk);
    $display("ran %0d transfers, %0d instruction steps, %0d characters out", sent_cnt,
             step_cnt, char_cnt);
    $display("all opcodes directed, random programs with stalls, halt at the end");
    if (errors == 0) begin
      $display("tb_lc3_instruction_step: PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_lc3_instruction_step: FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/lc3s_pkg.sv
hdl/lc3_instruction_step.sv
bench/lc3_step_checker.sv
bench/tb_lc3_instruction_step.sv
